FILE: src/pfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Playfair digraph cipher.
// Used by every module in src; depends on nothing else.
package pfc_pkg;

    localparam int LETTER_W = 5;
    localparam int ROWS     = 5;
    localparam int COLS     = 5;
    localparam int ROW_W    = COLS * LETTER_W;
    localparam int POS_W    = 3;
    localparam int CFG_W    = ROW_W;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;

    typedef logic [LETTER_W-1:0]       letter_t;
    typedef logic [ROWS-1:0][ROW_W-1:0] square_t;

    localparam logic [ROW_W-1:0] ROW0_RESET = 25'd4294688;
    localparam logic [ROW_W-1:0] ROW1_RESET = 25'd9706693;
    localparam logic [ROW_W-1:0] ROW2_RESET = 25'd15118698;
    localparam logic [ROW_W-1:0] ROW3_RESET = 25'd20530703;
    localparam logic [ROW_W-1:0] ROW4_RESET = 25'd25942708;

    typedef enum logic [2:0] {
        CFG_ROW0 = 3'd0,
        CFG_ROW1 = 3'd1,
        CFG_ROW2 = 3'd2,
        CFG_ROW3 = 3'd3,
        CFG_ROW4 = 3'd4,
        CFG_DIR  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        letter_t letter_in;
        logic    end_of_text;
    } src_item_t;

    typedef struct packed {
        letter_t letter_out;
        logic    end_of_run;
    } dst_item_t;

    // One digraph to encipher; twice marks a pair that is emitted two times.
    typedef struct packed {
        letter_t first;
        letter_t second;
        logic    twice;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } push_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } loc_t;

endpackage

FILE: src/playfair_digraph_cipher.sv
`timescale 1ns / 1ps
// A letter that completes a digraph pushes a job into the queue; the back end registers
// its results when it loads the job, and they follow one per cycle while the output is not stalled.
// Throughput: one letter per cycle until the four-entry job queue fills; the output sends
// one letter per cycle while not stalled, two for a digraph and four for a doubled final letter.
// Reset: rst_n clears the held letter, the queue and the output; the key square resets to
// the plain alphabet in row-major order and the direction to encrypt.
module playfair_digraph_cipher (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  pfc_pkg::src_item_t            src_item,
    output logic                          dst_valid,
    input  logic                          dst_stall,
    output pfc_pkg::dst_item_t            dst_item,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [pfc_pkg::CFG_W-1:0]     cfg_data
);

    pfc_pkg::square_t square_reg;
    logic             direction_reg;
    pfc_pkg::push_t   push;
    pfc_pkg::job_t    head;
    logic             full;
    logic             nonempty;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg[0] <= pfc_pkg::ROW0_RESET;
            square_reg[1] <= pfc_pkg::ROW1_RESET;
            square_reg[2] <= pfc_pkg::ROW2_RESET;
            square_reg[3] <= pfc_pkg::ROW3_RESET;
            square_reg[4] <= pfc_pkg::ROW4_RESET;
            direction_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (pfc_pkg::cfg_idx_t'(cfg_index))
                pfc_pkg::CFG_ROW0: square_reg[0] <= cfg_data;
                pfc_pkg::CFG_ROW1: square_reg[1] <= cfg_data;
                pfc_pkg::CFG_ROW2: square_reg[2] <= cfg_data;
                pfc_pkg::CFG_ROW3: square_reg[3] <= cfg_data;
                pfc_pkg::CFG_ROW4: square_reg[4] <= cfg_data;
                pfc_pkg::CFG_DIR:  direction_reg <= cfg_data[0];
                default:           direction_reg <= direction_reg;
            endcase
        end
    end

    pfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_item  (src_item),
        .full      (full),
        .src_stall (src_stall),
        .push      (push)
    );

    pfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .full     (full),
        .nonempty (nonempty),
        .head     (head)
    );

    pfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .square    (square_reg),
        .direction (direction_reg),
        .nonempty  (nonempty),
        .head      (head),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

FILE: src/pfc_front.sv
`timescale 1ns / 1ps
// Front end: accepts letters, holds the open digraph and classifies each item.
// Depends on pfc_pkg.
module pfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  pfc_pkg::src_item_t  src_item,
    input  logic                full,
    output logic                src_stall,
    output pfc_pkg::push_t      push
);

    pfc_pkg::letter_t pending_letter_reg;
    pfc_pkg::letter_t pending_letter_next;
    logic             pending_valid_reg;
    logic             pending_valid_next;
    logic             accept;

    assign src_stall = full;
    assign accept    = src_valid && !full;

    always_comb
    begin
        pending_letter_next = pending_letter_reg;
        pending_valid_next  = pending_valid_reg;
        push.push           = 1'b0;
        push.job.first      = src_item.letter_in;
        push.job.second     = pfc_pkg::LETTER_X;
        push.job.twice      = 1'b0;
        if (accept)
        begin
            priority if (!pending_valid_reg)
            begin
                if (src_item.end_of_text)
                begin
                    push.push = 1'b1;
                end
                else
                begin
                    pending_letter_next = src_item.letter_in;
                    pending_valid_next  = 1'b1;
                end
            end
            else if (src_item.letter_in != pending_letter_reg)
            begin
                push.push           = 1'b1;
                push.job.first      = pending_letter_reg;
                push.job.second     = src_item.letter_in;
                pending_valid_next  = 1'b0;
                pending_letter_next = '0;
            end
            else
            begin
                // A doubled letter takes the filler and stays held unless the text ends.
                push.push      = 1'b1;
                push.job.first = pending_letter_reg;
                push.job.twice = src_item.end_of_text;
                if (src_item.end_of_text)
                begin
                    pending_valid_next  = 1'b0;
                    pending_letter_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_letter_reg <= '0;
            pending_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_letter_reg <= pending_letter_next;
            pending_valid_reg  <= pending_valid_next;
        end
    end

endmodule

FILE: src/pfc_queue.sv
`timescale 1ns / 1ps
// Short queue of digraph jobs between the front end and the cipher back end.
// Depends on pfc_pkg.
module pfc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  pfc_pkg::push_t push,
    input  logic           pop,
    output logic           full,
    output logic           nonempty,
    output pfc_pkg::job_t  head
);

    pfc_pkg::job_t                   mem_reg [pfc_pkg::QDEPTH];
    logic [pfc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pfc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [pfc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pfc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [pfc_pkg::QCNT_W-1:0]      count_reg;
    logic [pfc_pkg::QCNT_W-1:0]      count_next;

    assign full     = (count_reg == pfc_pkg::QCNT_W'(pfc_pkg::QDEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

FILE: src/pfc_back.sv
`timescale 1ns / 1ps
// Back end: enciphers one digraph against the key square and sends its letters.
// Depends on pfc_pkg.
module pfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  pfc_pkg::square_t    square,
    input  logic                direction,
    input  logic                nonempty,
    input  pfc_pkg::job_t       head,
    output logic                pop,
    output logic                dst_valid,
    input  logic                dst_stall,
    output pfc_pkg::dst_item_t  dst_item
);

    function automatic pfc_pkg::loc_t locate(input pfc_pkg::square_t sq,
                                             input pfc_pkg::letter_t letter);
        pfc_pkg::loc_t loc;
        loc = '0;
        // Scanning backward leaves the first cell in row-major order.
        for (int r = pfc_pkg::ROWS - 1; r >= 0; r--)
        begin
            for (int c = pfc_pkg::COLS - 1; c >= 0; c--)
            begin
                if (sq[r][c*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] == letter)
                begin
                    loc.row = pfc_pkg::POS_W'(r);
                    loc.col = pfc_pkg::POS_W'(c);
                end
            end
        end
        return loc;
    endfunction

    function automatic logic [pfc_pkg::POS_W-1:0] step5(input logic [pfc_pkg::POS_W-1:0] v,
                                                        input logic back);
        logic [pfc_pkg::POS_W-1:0] res;
        if (back)
        begin
            res = (v == '0) ? pfc_pkg::POS_W'(pfc_pkg::COLS - 1) : v - 1'b1;
        end
        else
        begin
            res = (v == pfc_pkg::POS_W'(pfc_pkg::COLS - 1)) ? '0 : v + 1'b1;
        end
        return res;
    endfunction

    function automatic pfc_pkg::letter_t cell_at(input pfc_pkg::square_t sq,
                                                 input pfc_pkg::loc_t loc);
        logic [pfc_pkg::ROW_W-1:0] row;
        row = sq[loc.row];
        return row[loc.col*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
    endfunction

    pfc_pkg::loc_t    loc_a;
    pfc_pkg::loc_t    loc_b;
    pfc_pkg::loc_t    new_a;
    pfc_pkg::loc_t    new_b;
    pfc_pkg::letter_t first_reg;
    pfc_pkg::letter_t second_reg;
    logic             twice_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [1:0]       phase_reg;
    logic [1:0]       phase_next;
    logic             last_phase;
    logic             out_fire;
    logic             finishing;
    logic             load;

    always_comb
    begin
        loc_a = locate(square, head.first);
        loc_b = locate(square, head.second);
        new_a = loc_a;
        new_b = loc_b;
        priority if (loc_a.row == loc_b.row)
        begin
            new_a.col = step5(loc_a.col, direction);
            new_b.col = step5(loc_b.col, direction);
        end
        else if (loc_a.col == loc_b.col)
        begin
            new_a.row = step5(loc_a.row, direction);
            new_b.row = step5(loc_b.row, direction);
        end
        else
        begin
            new_a.col = loc_b.col;
            new_b.col = loc_a.col;
        end
    end

    assign last_phase = twice_reg ? (phase_reg == 2'd3) : (phase_reg == 2'd1);
    assign out_fire   = busy_reg && !dst_stall;
    assign finishing  = out_fire && last_phase;
    assign load       = nonempty && (!busy_reg || finishing);
    assign pop        = load;

    assign dst_valid           = busy_reg;
    assign dst_item.letter_out = phase_reg[0] ? second_reg : first_reg;
    assign dst_item.end_of_run = last_phase;

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        priority if (load)
        begin
            busy_next  = 1'b1;
            phase_next = '0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (out_fire)
        begin
            phase_next = phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            first_reg  <= cell_at(square, new_a);
            second_reg <= cell_at(square, new_b);
            twice_reg  <= head.twice;
        end
    end

`ifndef SYNTHESIS
    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !twice_reg |-> !phase_reg[1])
        else $error("Phase ran past the second letter of a single pair.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("Job taken from an empty queue.");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        finishing && !nonempty |=> !busy_reg)
        else $error("Back end stayed busy after its last transfer.");

    a_load_restart: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && phase_reg == 2'd0)
        else $error("A loaded job did not start at its first letter.");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for playfair_digraph_cipher: random and directed letter streams
// are checked against an in-bench digraph predictor under several key squares.
// Depends on pfc_pkg and the playfair_digraph_cipher RTL.
module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 8;
    localparam int REPORT_LIMIT = 10;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         src_valid = 1'b0;
    logic                         src_stall;
    pfc_pkg::src_item_t           src_item = '0;
    logic                         dst_valid;
    logic                         dst_stall;
    pfc_pkg::dst_item_t           dst_item;
    logic                         cfg_we = 1'b0;
    logic [2:0]                   cfg_index = pfc_pkg::CFG_ROW0;
    logic [pfc_pkg::CFG_W-1:0]    cfg_data = '0;

    logic                         burst_stall = 1'b0;
    logic                         hold_stall = 1'b0;
    logic                         idle_off = 1'b0;

    pfc_pkg::src_item_t           letter_queue[$];
    pfc_pkg::dst_item_t           cipher_queue[$];
    pfc_pkg::square_t             key_rows;
    logic                         key_dir = 1'b0;
    pfc_pkg::letter_t             held_letter = '0;
    logic                         held_valid = 1'b0;

    int                           items_queued = 0;
    int                           src_transfers = 0;
    int                           result_count = 0;
    int                           error_count = 0;
    int                           cycle_count = 0;
    int                           src_gap = 0;
    int                           stall_left = 0;
    int                           hold_left = 0;
    logic                         hold_done = 1'b0;
    pfc_pkg::dst_item_t           want_letter;

    assign dst_stall = burst_stall | hold_stall;

    playfair_digraph_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic pfc_pkg::letter_t square_cell(int r, int c);
        return key_rows[r][c*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W];
    endfunction

    // Scanning backward leaves the first row-major match; a missing letter lands on (0,0).
    function automatic pfc_pkg::loc_t find_cell(pfc_pkg::letter_t code);
        pfc_pkg::loc_t spot;
        spot = '0;
        for (int r = pfc_pkg::ROWS - 1; r >= 0; r--)
            for (int c = pfc_pkg::COLS - 1; c >= 0; c--)
                if (square_cell(r, c) == code)
                begin
                    spot.row = pfc_pkg::POS_W'(r);
                    spot.col = pfc_pkg::POS_W'(c);
                end
        return spot;
    endfunction

    function automatic logic [pfc_pkg::POS_W-1:0] step_mod5(logic [pfc_pkg::POS_W-1:0] v);
        return pfc_pkg::POS_W'(key_dir ? (int'(v) + 4) % 5 : (int'(v) + 1) % 5);
    endfunction

    task automatic add_result(pfc_pkg::dst_item_t res);
        cipher_queue.insert(cipher_queue.size(), res);
    endtask

    task automatic push_digraph(pfc_pkg::letter_t first, pfc_pkg::letter_t second,
                                logic closes);
        pfc_pkg::loc_t                p;
        pfc_pkg::loc_t                q;
        logic [pfc_pkg::POS_W-1:0]    t;
        pfc_pkg::dst_item_t           out;
        p = find_cell(first);
        q = find_cell(second);
        if (p.row == q.row)
        begin
            p.col = step_mod5(p.col);
            q.col = step_mod5(q.col);
        end
        else if (p.col == q.col)
        begin
            p.row = step_mod5(p.row);
            q.row = step_mod5(q.row);
        end
        else
        begin
            t = p.col;
            p.col = q.col;
            q.col = t;
        end
        out.letter_out = square_cell(p.row, p.col);
        out.end_of_run = 1'b0;
        add_result(out);
        out.letter_out = square_cell(q.row, q.col);
        out.end_of_run = closes;
        add_result(out);
    endtask

    task automatic encipher_letter(pfc_pkg::src_item_t item);
        if (!held_valid)
        begin
            if (!item.end_of_text)
            begin
                held_letter = item.letter_in;
                held_valid = 1'b1;
            end
            else
                push_digraph(item.letter_in, pfc_pkg::LETTER_X, 1'b1);
        end
        else if (item.letter_in != held_letter)
        begin
            push_digraph(held_letter, item.letter_in, 1'b1);
            held_valid = 1'b0;
        end
        else if (item.end_of_text)
        begin
            push_digraph(held_letter, pfc_pkg::LETTER_X, 1'b0);
            push_digraph(item.letter_in, pfc_pkg::LETTER_X, 1'b1);
            held_valid = 1'b0;
        end
        else
            push_digraph(held_letter, pfc_pkg::LETTER_X, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_item <= '0;
            src_gap = 0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                encipher_letter(src_item);
                src_transfers <= src_transfers + 1;
            end
            if (!(src_valid && src_stall))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (letter_queue.size() != 0)
                begin
                    src_item <= letter_queue.pop_front();
                    src_valid <= 1'b1;
                    if (!idle_off && cycle_count[7:6] != 2'b01 && $urandom_range(0, 4) == 0)
                        src_gap = $urandom_range(1, 8);
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            burst_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            burst_stall <= 1'b1;
        end
        else if (!idle_off && cycle_count[6:5] != 2'b10 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            burst_stall <= 1'b1;
        end
        else
            burst_stall <= 1'b0;
    end

    // One long receiver hold-off so the job queue fills and the input backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && src_transfers >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            hold_stall <= (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dst_valid && !dst_stall)
        begin
            result_count++;
            if (cipher_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("ERROR: unexpected output transfer %0d: letter %0d end %0b",
                             result_count, dst_item.letter_out, dst_item.end_of_run);
            end
            else
            begin
                want_letter = cipher_queue.pop_front();
                if (dst_item.letter_out !== want_letter.letter_out ||
                    dst_item.end_of_run !== want_letter.end_of_run)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("ERROR: transfer %0d: expected %0d/%0b, got %0d/%0b",
                                 result_count, want_letter.letter_out,
                                 want_letter.end_of_run,
                                 dst_item.letter_out, dst_item.end_of_run);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic add_letter(pfc_pkg::letter_t code, logic last);
        pfc_pkg::src_item_t item;
        item.letter_in = code;
        item.end_of_text = last;
        letter_queue.insert(letter_queue.size(), item);
        items_queued++;
    endtask

    // Messages of random length, biased toward doubled letters and the filler letter.
    task automatic queue_messages(int count);
        int                left;
        int                len;
        int                pick;
        pfc_pkg::letter_t  code;
        left = count;
        code = '0;
        while (left > 0)
        begin
            len = $urandom_range(1, 10);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 9);
                if (i > 0 && pick < 2)
                    code = code;
                else if (pick == 2)
                    code = pfc_pkg::LETTER_X;
                else
                    code = pfc_pkg::letter_t'($urandom_range(0, 24));
                add_letter(code, i == len - 1 || $urandom_range(0, 19) == 0);
            end
            left -= len;
        end
    endtask

    function automatic pfc_pkg::square_t random_square(logic repeats);
        pfc_pkg::letter_t  codes[pfc_pkg::ROWS*pfc_pkg::COLS];
        pfc_pkg::letter_t  t;
        int                j;
        pfc_pkg::square_t  sq;
        for (int i = 0; i < pfc_pkg::ROWS * pfc_pkg::COLS; i++)
            codes[i] = repeats ? pfc_pkg::letter_t'($urandom_range(0, 24))
                               : pfc_pkg::letter_t'(i);
        for (int i = pfc_pkg::ROWS * pfc_pkg::COLS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = codes[i];
            codes[i] = codes[j];
            codes[j] = t;
        end
        for (int i = 0; i < pfc_pkg::ROWS * pfc_pkg::COLS; i++)
            sq[i / pfc_pkg::COLS][(i % pfc_pkg::COLS)*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W]
                = codes[i];
        return sq;
    endfunction

    task automatic write_register(pfc_pkg::cfg_idx_t idx, logic [pfc_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == pfc_pkg::CFG_DIR)
            key_dir = value[0];
        else
            key_rows[idx] = value;
    endtask

    task automatic load_key(pfc_pkg::square_t sq, logic dir);
        for (int r = 0; r < pfc_pkg::ROWS; r++)
            write_register(pfc_pkg::cfg_idx_t'(r), sq[r]);
        write_register(pfc_pkg::CFG_DIR, pfc_pkg::CFG_W'(dir));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (src_transfers != items_queued || cipher_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int      directed_codes[21];
        int      directed_ends[21];
        directed_codes = '{0, 0, 1, 3, 4, 0, 20, 0, 24, 24, 24, 7, 15, 15, pfc_pkg::LETTER_X,
                           16, 8, 12, 17, pfc_pkg::LETTER_X, pfc_pkg::LETTER_X};
        directed_ends  = '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1,
                           0, 1, 0, 0, 0, 1};
        for (int r = 0; r < pfc_pkg::ROWS; r++)
            for (int c = 0; c < pfc_pkg::COLS; c++)
                key_rows[r][c*pfc_pkg::LETTER_W +: pfc_pkg::LETTER_W] =
                    pfc_pkg::LETTER_W'(r * pfc_pkg::COLS + c);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 21; i++)
            add_letter(pfc_pkg::letter_t'(directed_codes[i]), directed_ends[i] != 0);
        drain();

        load_key(random_square(1'b0), 1'b1);
        queue_messages(120);
        drain();

        load_key('1, 1'b1);
        queue_messages(16);
        drain();

        load_key('0, 1'b0);
        queue_messages(16);
        drain();

        load_key(random_square(1'b1), 1'b1);
        queue_messages(100);
        drain();

        idle_off <= 1'b1;
        load_key(random_square(1'b0), 1'b0);
        queue_messages(130);
        drain();

        if (cipher_queue.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_queue.sv
src/pfc_back.sv
src/playfair_digraph_cipher.sv
verif/tb.sv
